>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL files of the touch digitiser codec.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Clocked check, disabled while reset is asserted.
`define TDC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked check that also holds during reset.
`define TDC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TDC_ASSERT(lbl, prop, msg)
`define TDC_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

>>> hw/rtl/tdc_pkg.sv
// Package with codes, constants, types and sample helpers of the touch digitiser codec.
`timescale 1ns / 1ps
package tdc_pkg;

    // Bus commands.
    localparam logic [1:0] CMD_READ  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_PEN   = 2'd2;
    localparam logic [1:0] CMD_POP   = 2'd3;

    // Register addresses.
    localparam logic [7:0] REG_REVISION = 8'h5A;
    localparam logic [7:0] REG_DIG1     = 8'h74;
    localparam logic [7:0] REG_DIGRD    = 8'h7A;
    localparam logic [7:0] REG_VENDOR1  = 8'h7C;
    localparam logic [7:0] REG_VENDOR2  = 8'h7E;

    // Reset values and field masks.
    localparam logic [15:0] VENDOR1_VAL  = 16'h574D;
    localparam logic [15:0] VENDOR2_VAL  = 16'h4C13;
    localparam logic [15:0] REVISION_VAL = 16'h0008;
    localparam logic [15:0] DIG_SEL_MASK = 16'h00FE;
    localparam logic [15:0] DIG_CONT     = 16'h0100;
    localparam logic [15:0] DIG_POLL     = 16'h0200;
    localparam logic [15:0] PEN_BIT      = 16'h8000;
    localparam logic [11:0] DATA_ONES    = 12'hFFF;

    // Channel select numbers.
    localparam logic [2:0] CH_X     = 3'd1;
    localparam logic [2:0] CH_Y     = 3'd2;
    localparam logic [2:0] CH_PRESS = 3'd3;
    localparam logic [2:0] CH_LAST  = 3'd7;

    typedef struct packed {
        logic       capture;
        logic       latch_pen;
        logic       rd_capture;
        logic       reg_write;
        logic       poll_write;
        logic       push;
        logic       pop_issue;
        logic       pop_capture;
        logic       load_out;
        logic [2:0] bit_idx;
    } tdc_cmd_t;

    typedef struct packed {
        logic in_range;
        logic is_poll;
        logic poll_has_sel;
        logic cont_on;
        logic sel_bit;
        logic fifo_nonempty;
        logic out_free;
    } tdc_status_t;

    function automatic logic [15:0] reg_reset_value(input logic [7:0] addr);
        logic [15:0] v;
        case (addr)
            REG_REVISION: v = REVISION_VAL;
            REG_VENDOR1:  v = VENDOR1_VAL;
            REG_VENDOR2:  v = VENDOR2_VAL;
            default:      v = 16'h0000;
        endcase
        return v;
    endfunction

    function automatic logic chan_bad(input logic [2:0] ch);
        return (ch != CH_X) && (ch != CH_Y) && (ch != CH_PRESS);
    endfunction

    function automatic logic [15:0] make_sample(input logic pen, input logic [2:0] ch,
                                                input logic [11:0] x, input logic [11:0] y);
        logic [11:0] data;
        if (ch == CH_X) begin
            data = x;
        end else if (ch == CH_Y) begin
            data = y;
        end else begin
            data = DATA_ONES;
        end
        return (pen ? PEN_BIT : 16'h0000) | {1'b0, ch, data};
    endfunction

    // Lowest set bit among select bits 7:1.
    function automatic logic [2:0] lowest_sel(input logic [15:0] v);
        logic [2:0] r;
        r = 3'd0;
        for (int b = 7; b >= 1; b--) begin
            if (v[b]) begin
                r = 3'(b);
            end
        end
        return r;
    endfunction

endpackage

>>> hw/rtl/touch_digitiser_codec_regs.sv
// Top level of the codec register file with touch digitiser.
`timescale 1ns / 1ps
//
//  Channel | Handshake            | Beat contents
//  --------+----------------------+-----------------------------------------------
//  in      | in_valid / in_stall  | command, reg_addr, write_data, pen_down, raw_x,
//          |                      | raw_y
//  out     | out_valid / out_stall| read_data, slot_valid, slot_word, channel_error
//
// One input beat is worked on at a time and yields exactly one output beat.
// A read is captured in S_READ; a write is stored in S_WRITE and a poll then
// samples into the readback register in S_POLL; a pop checks the FIFO in S_POP
// and takes the word in S_POPDATA. A pen update in continuous mode walks S_PUSH
// over select bits 7:1, pushing one FIFO word a cycle for each set bit through
// the single FIFO write port. A stalled output beat holds the finished command
// until the result register frees. Reset is asynchronous and active low; a
// written flag per register lets unwritten entries read their reset values,
// so no clearing pass follows reset.
module touch_digitiser_codec_regs
    import tdc_pkg::*;
#(
    parameter int NUM_REGS   = 128,
    parameter int FIFO_DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  command,
    input  logic [7:0]  reg_addr,
    input  logic [15:0] write_data,
    input  logic        pen_down,
    input  logic [11:0] raw_x,
    input  logic [11:0] raw_y,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] read_data,
    output logic        slot_valid,
    output logic [15:0] slot_word,
    output logic        channel_error
);

`include "assert_macros.svh"

    tdc_cmd_t    cmd;
    tdc_status_t sts;

    // The controller only sequences; all state of the codec lives in the datapath.
    tdc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .command  (command),
        .sts      (sts),
        .cmd      (cmd)
    );

    // The datapath holds the register file, the pen latch, the sample FIFO and
    // the output register that decouples the two channels.
    tdc_dp #(
        .NUM_REGS   (NUM_REGS),
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .reg_addr      (reg_addr),
        .write_data    (write_data),
        .pen_down      (pen_down),
        .raw_x         (raw_x),
        .raw_y         (raw_y),
        .cmd           (cmd),
        .sts           (sts),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .read_data     (read_data),
        .slot_valid    (slot_valid),
        .slot_word     (slot_word),
        .channel_error (channel_error)
    );

    // An accepted beat keeps the input stalled until its result is loaded.
    `TDC_ASSERT(a_accept_then_busy, (in_valid && !in_stall) |=> in_stall, "input not stalled after accept")
    // Loading the result register always raises the output beat.
    `TDC_ASSERT(a_load_shows_beat, cmd.load_out |=> out_valid, "loaded result not presented")
    // A pop is only issued against a FIFO that holds a word.
    `TDC_ASSERT(a_pop_nonempty, cmd.pop_issue |-> sts.fifo_nonempty, "pop issued on empty FIFO")
    // The controller drives at most one datapath operation per cycle.
    `TDC_ASSERT_ALWAYS(a_one_op, $onehot0({cmd.capture, cmd.rd_capture, cmd.reg_write, cmd.poll_write, cmd.push, cmd.pop_issue, cmd.pop_capture, cmd.load_out}), "overlapping datapath operations")

endmodule

>>> hw/rtl/tdc_ram.sv
// Generic single write port RAM with a registered read port.
`timescale 1ns / 1ps
module tdc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> hw/rtl/tdc_ctrl.sv
// Controller state machine that sequences each command of the touch digitiser codec.
`timescale 1ns / 1ps
module tdc_ctrl
    import tdc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  command,
    input  tdc_status_t sts,
    output tdc_cmd_t    cmd
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_READ    = 3'd1;
    localparam logic [2:0] S_WRITE   = 3'd2;
    localparam logic [2:0] S_POLL    = 3'd3;
    localparam logic [2:0] S_PUSH    = 3'd4;
    localparam logic [2:0] S_POP     = 3'd5;
    localparam logic [2:0] S_POPDATA = 3'd6;
    localparam logic [2:0] S_DONE    = 3'd7;

    logic [2:0] state_reg, state_next;
    logic [2:0] bit_reg, bit_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            bit_reg   <= CH_X;
        end
        else
        begin
            state_reg <= state_next;
            bit_reg   <= bit_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        bit_next   = bit_reg;
        cmd        = '0;
        cmd.bit_idx = bit_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    unique case (command)
                        CMD_READ:  state_next = S_READ;
                        CMD_WRITE: state_next = S_WRITE;
                        CMD_PEN:
                        begin
                            cmd.latch_pen = 1'b1;
                            bit_next      = CH_X;
                            state_next    = sts.cont_on ? S_PUSH : S_DONE;
                        end
                        CMD_POP:   state_next = S_POP;
                    endcase
                end
            end
            S_READ:
            begin
                cmd.rd_capture = 1'b1;
                state_next     = S_DONE;
            end
            S_WRITE:
            begin
                cmd.reg_write = 1'b1;
                if (sts.in_range && sts.is_poll && sts.poll_has_sel)
                begin
                    state_next = S_POLL;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_POLL:
            begin
                cmd.poll_write = 1'b1;
                state_next     = S_DONE;
            end
            S_PUSH:
            begin
                cmd.push = sts.sel_bit;
                if (bit_reg == CH_LAST)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    bit_next = bit_reg + 3'd1;
                end
            end
            S_POP:
            begin
                if (sts.fifo_nonempty)
                begin
                    cmd.pop_issue = 1'b1;
                    state_next    = S_POPDATA;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_POPDATA:
            begin
                cmd.pop_capture = 1'b1;
                state_next      = S_DONE;
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

>>> hw/rtl/tdc_dp.sv
// Datapath of the touch digitiser codec: register file, pen latch, sample FIFO, result register.
`timescale 1ns / 1ps
module tdc_dp
    import tdc_pkg::*;
#(
    parameter int NUM_REGS   = 128,
    parameter int FIFO_DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  reg_addr,
    input  logic [15:0] write_data,
    input  logic        pen_down,
    input  logic [11:0] raw_x,
    input  logic [11:0] raw_y,
    input  tdc_cmd_t    cmd,
    output tdc_status_t sts,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] read_data,
    output logic        slot_valid,
    output logic [15:0] slot_word,
    output logic        channel_error
);

    localparam int RAW = $clog2(NUM_REGS);
    localparam int PW  = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CW  = $clog2(FIFO_DEPTH + 1);

    // Captured command fields and pen latch.
    logic [7:0]  addr_reg, addr_next;
    logic [15:0] wdata_reg, wdata_next;
    logic        pen_reg, pen_next;
    logic [11:0] x_reg, x_next;
    logic [11:0] y_reg, y_next;
    logic [15:0] dig1_reg, dig1_next;

    // Register file entries that have been written since reset.
    logic [NUM_REGS-1:0] valid_reg, valid_next;

    // FIFO pointers.
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    // Result being built, and the output register.
    logic [15:0] res_read_reg, res_read_next;
    logic        res_valid_reg, res_valid_next;
    logic [15:0] res_word_reg, res_word_next;
    logic        res_err_reg, res_err_next;
    logic        out_valid_reg, out_valid_next;
    logic [15:0] out_read_reg, out_read_next;
    logic        out_slot_reg, out_slot_next;
    logic [15:0] out_word_reg, out_word_next;
    logic        out_err_reg, out_err_next;

    logic           rf_we;
    logic [RAW-1:0] rf_waddr;
    logic [15:0]    rf_wdata;
    logic [15:0]    rf_rdata;
    logic           fifo_we;
    logic [15:0]    fifo_wdata;
    logic [15:0]    fifo_rdata;

    logic [RAW-1:0] addr_idx;
    logic [7:0]     sel_byte;
    logic [2:0]     poll_ch;
    logic [15:0]    poll_sample;
    logic           fifo_full;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    tdc_ram #(.WIDTH(16), .DEPTH(NUM_REGS)) u_regfile (
        .clk   (clk),
        .we    (rf_we),
        .waddr (rf_waddr),
        .wdata (rf_wdata),
        .raddr (reg_addr[RAW-1:0]),
        .rdata (rf_rdata)
    );

    tdc_ram #(.WIDTH(16), .DEPTH(FIFO_DEPTH)) u_fifo (
        .clk   (clk),
        .we    (fifo_we),
        .waddr (wr_ptr_reg),
        .wdata (fifo_wdata),
        .raddr (rd_ptr_reg),
        .rdata (fifo_rdata)
    );

    assign addr_idx    = addr_reg[RAW-1:0];
    assign sel_byte    = dig1_reg[7:0];
    assign poll_ch     = lowest_sel(wdata_reg);
    assign poll_sample = make_sample(pen_reg, poll_ch, x_reg, y_reg);
    assign fifo_full   = (count_reg == CW'(FIFO_DEPTH));
    assign fifo_wdata  = make_sample(pen_reg, cmd.bit_idx, x_reg, y_reg);

    always_comb
    begin
        sts.in_range      = ({1'b0, addr_reg} < 9'(NUM_REGS));
        sts.is_poll       = (addr_reg == REG_DIG1) && ((wdata_reg & DIG_POLL) != 16'h0000);
        sts.poll_has_sel  = ((wdata_reg & DIG_SEL_MASK) != 16'h0000);
        sts.cont_on       = ((dig1_reg & DIG_CONT) != 16'h0000);
        sts.sel_bit       = sel_byte[cmd.bit_idx];
        sts.fifo_nonempty = (count_reg != '0);
        sts.out_free      = !out_valid_reg || !out_stall;
    end

    always_comb
    begin
        addr_next      = addr_reg;
        wdata_next     = wdata_reg;
        pen_next       = pen_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        dig1_next      = dig1_reg;
        valid_next     = valid_reg;
        rd_ptr_next    = rd_ptr_reg;
        wr_ptr_next    = wr_ptr_reg;
        count_next     = count_reg;
        res_read_next  = res_read_reg;
        res_valid_next = res_valid_reg;
        res_word_next  = res_word_reg;
        res_err_next   = res_err_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_read_next  = out_read_reg;
        out_slot_next  = out_slot_reg;
        out_word_next  = out_word_reg;
        out_err_next   = out_err_reg;
        rf_we          = 1'b0;
        rf_waddr       = addr_idx;
        rf_wdata       = wdata_reg;
        fifo_we        = 1'b0;

        if (cmd.capture)
        begin
            addr_next      = reg_addr;
            wdata_next     = write_data;
            res_read_next  = 16'h0000;
            res_valid_next = 1'b0;
            res_word_next  = 16'h0000;
            res_err_next   = 1'b0;
        end
        if (cmd.latch_pen)
        begin
            pen_next = pen_down;
            x_next   = raw_x;
            y_next   = raw_y;
        end
        if (cmd.rd_capture && sts.in_range)
        begin
            res_read_next = valid_reg[addr_idx] ? rf_rdata : reg_reset_value(addr_reg);
        end
        if (cmd.reg_write && sts.in_range)
        begin
            rf_we = 1'b1;
            rf_wdata = sts.is_poll ? (wdata_reg & ~DIG_POLL) : wdata_reg;
            valid_next[addr_idx] = 1'b1;
            if (addr_reg == REG_DIG1)
            begin
                dig1_next = rf_wdata;
            end
        end
        if (cmd.poll_write)
        begin
            rf_we    = 1'b1;
            rf_waddr = REG_DIGRD[RAW-1:0];
            rf_wdata = poll_sample;
            valid_next[REG_DIGRD[RAW-1:0]] = 1'b1;
            if (chan_bad(poll_ch))
            begin
                res_err_next = 1'b1;
            end
        end
        if (cmd.push)
        begin
            // A full FIFO loses its oldest word to make room.
            fifo_we     = 1'b1;
            wr_ptr_next = ptr_inc(wr_ptr_reg);
            if (fifo_full)
            begin
                rd_ptr_next = ptr_inc(rd_ptr_reg);
            end
            else
            begin
                count_next = count_reg + 1'b1;
            end
            if (chan_bad(cmd.bit_idx))
            begin
                res_err_next = 1'b1;
            end
        end
        if (cmd.pop_issue)
        begin
            rd_ptr_next    = ptr_inc(rd_ptr_reg);
            count_next     = count_reg - 1'b1;
            res_valid_next = 1'b1;
        end
        if (cmd.pop_capture)
        begin
            res_word_next = fifo_rdata;
        end
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
            out_read_next  = res_read_reg;
            out_slot_next  = res_valid_reg;
            out_word_next  = res_word_reg;
            out_err_next   = res_err_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pen_reg       <= 1'b0;
            x_reg         <= '0;
            y_reg         <= '0;
            dig1_reg      <= '0;
            valid_reg     <= '0;
            rd_ptr_reg    <= '0;
            wr_ptr_reg    <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pen_reg       <= pen_next;
            x_reg         <= x_next;
            y_reg         <= y_next;
            dig1_reg      <= dig1_next;
            valid_reg     <= valid_next;
            rd_ptr_reg    <= rd_ptr_next;
            wr_ptr_reg    <= wr_ptr_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg      <= addr_next;
        wdata_reg     <= wdata_next;
        res_read_reg  <= res_read_next;
        res_valid_reg <= res_valid_next;
        res_word_reg  <= res_word_next;
        res_err_reg   <= res_err_next;
        out_read_reg  <= out_read_next;
        out_slot_reg  <= out_slot_next;
        out_word_reg  <= out_word_next;
        out_err_reg   <= out_err_next;
    end

    assign out_valid     = out_valid_reg;
    assign read_data     = out_read_reg;
    assign slot_valid    = out_slot_reg;
    assign slot_word     = out_word_reg;
    assign channel_error = out_err_reg;

endmodule

>>> tb/tb_touch_digitiser_codec_regs.sv
// Self-checking testbench for the codec register file with touch digitiser.
`timescale 1ns / 1ps

// The bench keeps a shadow copy of the codec: its register bank, the latched
// pen state and the tagged-sample FIFO. The driver predicts the response of
// every beat at the edge where the block accepts it. The monitor checks the
// output beats in order against those predictions.
// The stimulus starts with a short directed list:
// - vendor and revision reads;
// - out-of-range addresses;
// - a poll with no channel selected;
// - polls of a modelled and an unmodelled channel;
// - continuous pushes that overflow the FIFO;
// - a pop on an empty FIFO.
// After that come random digitiser sessions, register write/read pairs and
// pure noise.
module tb_touch_digitiser_codec_regs;
    import tdc_pkg::*;

    localparam int TB_NUM_REGS   = 128;
    localparam int TB_FIFO_DEPTH = 16;
    localparam int RANDOM_ITEMS  = 1300;
    // The receiver's long hold-off. It starts once this many results have been
    // checked.
    localparam int HOLD_CYCLES   = 400;
    localparam int HOLD_AFTER    = 600;
    // This bound is generous; a run that reaches it has hung.
    localparam int CYCLE_LIMIT   = 250000;
    // The longest command is a continuous pen update, and the drain at the end
    // outlasts it.
    localparam int DRAIN_CYCLES  = 40;

    typedef struct packed {
        logic [1:0]  command;
        logic [7:0]  reg_addr;
        logic [15:0] write_data;
        logic        pen_down;
        logic [11:0] raw_x;
        logic [11:0] raw_y;
    } codec_req_t;

    typedef struct packed {
        logic [15:0] read_data;
        logic        slot_valid;
        logic [15:0] slot_word;
        logic        channel_error;
    } codec_resp_t;

    // Every block input is given a known value from time zero.
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  command = CMD_READ;
    logic [7:0]  reg_addr = '0;
    logic [15:0] write_data = '0;
    logic        pen_down = 1'b0;
    logic [11:0] raw_x = '0;
    logic [11:0] raw_y = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [15:0] read_data;
    logic        slot_valid;
    logic [15:0] slot_word;
    logic        channel_error;

    // This is the shadow state of the codec.
    logic [15:0] shadow_regs [TB_NUM_REGS];
    logic        pen_q;
    logic [11:0] pen_x_q;
    logic [11:0] pen_y_q;
    logic [15:0] fifo_words [$];

    codec_req_t  req_backlog [$];
    codec_resp_t awaited_resps [$];
    codec_req_t  cur_req;

    int cycle_count = 0;
    int fail_count = 0;
    int n_checked = 0;
    int n_reads = 0;
    int n_writes = 0;
    int n_polls = 0;
    int n_pens = 0;
    int n_pen_cont = 0;
    int n_pops_hit = 0;
    int n_chan_err = 0;

    // These counters belong to the sender.
    int burst_left = 4;
    int gap_left = 0;

    // These counters belong to the receiver.
    int hold_left = 0;
    bit hold_done = 1'b0;
    int stall_phase = 0;
    bit stall_next;

    touch_digitiser_codec_regs #(
        .NUM_REGS   (TB_NUM_REGS),
        .FIFO_DEPTH (TB_FIFO_DEPTH)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .command       (command),
        .reg_addr      (reg_addr),
        .write_data    (write_data),
        .pen_down      (pen_down),
        .raw_x         (raw_x),
        .raw_y         (raw_y),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .read_data     (read_data),
        .slot_valid    (slot_valid),
        .slot_word     (slot_word),
        .channel_error (channel_error)
    );

    always #6 clk = ~clk;

    // A tagged sample is the pen bit, the channel number and 12 data bits.
    // X and Y carry the latched coordinates. Any other channel reads all
    // ones. Channels above pressure are also flagged as unmodelled.
    function automatic logic [15:0] sample_word(input logic [2:0] ch, output logic bad);
        logic [11:0] data;
        bad = 1'b0;
        if (ch == CH_X) begin
            data = pen_x_q;
        end else if (ch == CH_Y) begin
            data = pen_y_q;
        end else begin
            data = DATA_ONES;
            bad = (ch != CH_PRESS);
        end
        return {pen_q, ch, data};
    endfunction

    // This applies one command to the shadow state and returns the response
    // that the block must produce for it.
    function automatic codec_resp_t run_codec_cmd(input codec_req_t r);
        codec_resp_t res;
        logic [15:0] dig;
        logic [15:0] w;
        logic        bad;
        bit          found;
        res = '0;
        found = 1'b0;
        case (r.command)
            CMD_READ: begin
                n_reads++;
                if (int'(r.reg_addr) < TB_NUM_REGS) begin
                    res.read_data = shadow_regs[r.reg_addr];
                end
            end
            CMD_WRITE: begin
                n_writes++;
                if (int'(r.reg_addr) < TB_NUM_REGS) begin
                    shadow_regs[r.reg_addr] = r.write_data;
                    if (r.reg_addr == REG_DIG1 && (r.write_data & DIG_POLL) != 0) begin
                        n_polls++;
                        shadow_regs[REG_DIG1] = r.write_data & ~DIG_POLL;
                        // Only the lowest selected channel is sampled into the
                        // readback register.
                        for (int b = 1; b <= 7; b++) begin
                            if (!found && r.write_data[b]) begin
                                found = 1'b1;
                                shadow_regs[REG_DIGRD] = sample_word(3'(b), bad);
                                res.channel_error = bad;
                            end
                        end
                    end
                end
            end
            CMD_PEN: begin
                n_pens++;
                dig = shadow_regs[REG_DIG1];
                pen_q = r.pen_down;
                pen_x_q = r.raw_x;
                pen_y_q = r.raw_y;
                if ((dig & DIG_CONT) != 0) begin
                    n_pen_cont++;
                    for (int b = 1; b <= 7; b++) begin
                        if (dig[b]) begin
                            w = sample_word(3'(b), bad);
                            res.channel_error = res.channel_error | bad;
                            // A full FIFO loses its oldest word to make room.
                            if (fifo_words.size() >= TB_FIFO_DEPTH) begin
                                fifo_words.delete(0);
                            end
                            fifo_words.insert(fifo_words.size(), w);
                        end
                    end
                end
            end
            default: begin
                if (fifo_words.size() != 0) begin
                    n_pops_hit++;
                    res.slot_valid = 1'b1;
                    res.slot_word = fifo_words[0];
                    fifo_words.delete(0);
                end
            end
        endcase
        if (res.channel_error) begin
            n_chan_err++;
        end
        return res;
    endfunction

    // This queues a bus command. The pen fields carry random filler.
    function automatic void queue_bus(input logic [1:0] cmd, input logic [7:0] addr,
                                      input logic [15:0] data);
        codec_req_t r;
        r.command = cmd;
        r.reg_addr = addr;
        r.write_data = data;
        r.pen_down = 1'($urandom);
        r.raw_x = 12'($urandom);
        r.raw_y = 12'($urandom);
        req_backlog.insert(req_backlog.size(), r);
    endfunction

    // This queues a pen update. The bus fields carry random filler.
    function automatic void queue_pen(input logic pen, input logic [11:0] x,
                                      input logic [11:0] y);
        codec_req_t r;
        r.command = CMD_PEN;
        r.reg_addr = 8'($urandom);
        r.write_data = 16'($urandom);
        r.pen_down = pen;
        r.raw_x = x;
        r.raw_y = y;
        req_backlog.insert(req_backlog.size(), r);
    endfunction

    function automatic void build_stimulus();
        int          directed_n;
        int          kind;
        int          reps;
        logic [15:0] ctl;
        logic [7:0]  addr;

        // The directed part comes first.
        queue_bus(CMD_READ, REG_VENDOR1, 16'h0000);
        queue_bus(CMD_READ, REG_VENDOR2, 16'h0000);
        queue_bus(CMD_READ, REG_REVISION, 16'h0000);
        // Addresses past the table read zero and ignore writes.
        queue_bus(CMD_READ, 8'hFF, 16'hFFFF);
        queue_bus(CMD_WRITE, 8'h80, 16'hFFFF);
        queue_bus(CMD_READ, 8'h80, 16'h0000);
        queue_bus(CMD_WRITE, 8'h00, 16'hFFFF);
        queue_bus(CMD_READ, 8'h00, 16'h0000);
        // A pop on an empty FIFO returns no word.
        queue_bus(CMD_POP, 8'h00, 16'h0000);
        // A pen update without continuous mode only latches the pen.
        queue_pen(1'b1, 12'hFFF, 12'h000);
        // A poll with nothing selected leaves the readback register alone.
        queue_bus(CMD_WRITE, REG_DIG1, DIG_POLL);
        queue_bus(CMD_READ, REG_DIG1, 16'h0000);
        queue_bus(CMD_READ, REG_DIGRD, 16'h0000);
        // A poll of X samples the latched coordinate.
        queue_bus(CMD_WRITE, REG_DIG1, DIG_POLL | (16'h1 << CH_X));
        queue_bus(CMD_READ, REG_DIGRD, 16'h0000);
        // Select bit 5 is an unmodelled channel and raises the error flag.
        queue_bus(CMD_WRITE, REG_DIG1, DIG_POLL | (16'h1 << 5));
        queue_bus(CMD_READ, REG_DIGRD, 16'h0000);
        // Continuous mode is on for every channel. Three pen updates push 21
        // words, so the FIFO overflows.
        queue_bus(CMD_WRITE, REG_DIG1, DIG_CONT | DIG_SEL_MASK);
        queue_pen(1'b1, 12'hABC, 12'h123);
        queue_pen(1'b0, 12'h000, 12'hFFF);
        queue_pen(1'b1, 12'hFFF, 12'h000);
        queue_bus(CMD_POP, 8'hFF, 16'hFFFF);
        queue_bus(CMD_POP, 8'h00, 16'h0000);
        // The identification registers are ordinary storage.
        queue_bus(CMD_WRITE, REG_VENDOR1, 16'h0000);
        queue_bus(CMD_READ, REG_VENDOR1, 16'h0000);
        directed_n = req_backlog.size();

        // The random part follows. Most of it is digitiser sessions: a
        // control write, some pen updates and a run of pops.
        while (req_backlog.size() < directed_n + RANDOM_ITEMS) begin
            kind = $urandom_range(0, 9);
            if (kind < 6) begin
                ctl = 16'($urandom);
                ctl[8] = ($urandom_range(0, 3) != 0);
                ctl[9] = ($urandom_range(0, 1) != 0);
                // About half the sessions select only the modelled channels.
                if ($urandom_range(0, 1) != 0) begin
                    ctl[7:1] = {4'b0000, 3'($urandom)};
                end
                queue_bus(CMD_WRITE, REG_DIG1, ctl);
                if (ctl[9]) begin
                    queue_bus(CMD_READ, REG_DIGRD, 16'($urandom));
                end
                reps = $urandom_range(1, 4);
                repeat (reps) begin
                    queue_pen(1'($urandom), 12'($urandom), 12'($urandom));
                end
                reps = $urandom_range(1, 10);
                repeat (reps) begin
                    queue_bus(CMD_POP, 8'($urandom), 16'($urandom));
                end
                if ($urandom_range(0, 3) == 0) begin
                    queue_bus(CMD_READ, REG_DIG1, 16'($urandom));
                end
            end else if (kind < 8) begin
                addr = 8'($urandom);
                queue_bus(CMD_WRITE, addr, 16'($urandom));
                queue_bus(CMD_READ, addr, 16'($urandom));
            end else begin
                queue_bus(2'($urandom), 8'($urandom), 16'($urandom));
            end
        end
    endfunction

    function automatic void report_mismatch(input string field, input logic [15:0] exp_v,
                                            input logic [15:0] act_v);
        fail_count++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, field, exp_v, act_v);
    endfunction

    // The driver takes pending items in bursts of random length with random
    // gaps between them. A beat that is offered holds still until it is taken.
    // Its response is predicted at the edge where the block accepts it.
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) begin
                awaited_resps.insert(awaited_resps.size(), run_codec_cmd(cur_req));
            end
            if (!in_valid || !in_stall) begin
                if (gap_left != 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if (req_backlog.size() != 0) begin
                    cur_req = req_backlog[0];
                    req_backlog.delete(0);
                    command <= cur_req.command;
                    reg_addr <= cur_req.reg_addr;
                    write_data <= cur_req.write_data;
                    pen_down <= cur_req.pen_down;
                    raw_x <= cur_req.raw_x;
                    raw_y <= cur_req.raw_y;
                    in_valid <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0) begin
                        // Some bursts are long. They give stretches with no
                        // idling at all.
                        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                                 : $urandom_range(1, 8);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // The monitor checks each accepted output beat against the oldest
    // prediction. It also drives the receiver's stall with a pattern of its
    // own, in three windows:
    // - a window that never stalls;
    // - a window of regular, evenly spaced stalls;
    // - a window of random stalls.
    // Once, partway through the run, it holds off for a long stretch. The
    // sender keeps offering during the hold, so the block backs up and stalls
    // its input.
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                n_checked++;
                if (awaited_resps.size() == 0) begin
                    fail_count++;
                    $display("%0t: output beat with no prediction waiting, expected none, actual %h %b %h %b",
                             $time, read_data, slot_valid, slot_word, channel_error);
                end else begin
                    codec_resp_t e;
                    e = awaited_resps[0];
                    awaited_resps.delete(0);
                    if (read_data !== e.read_data) begin
                        report_mismatch("read_data", e.read_data, read_data);
                    end
                    if (slot_valid !== e.slot_valid) begin
                        report_mismatch("slot_valid", 16'(e.slot_valid), 16'(slot_valid));
                    end
                    if (slot_word !== e.slot_word) begin
                        report_mismatch("slot_word", e.slot_word, slot_word);
                    end
                    if (channel_error !== e.channel_error) begin
                        report_mismatch("channel_error", 16'(e.channel_error),
                                        16'(channel_error));
                    end
                end
            end
            if (hold_left != 0) begin
                hold_left--;
                stall_next = 1'b1;
            end else if (!hold_done && n_checked >= HOLD_AFTER) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                stall_next = 1'b1;
            end else begin
                stall_phase = (stall_phase + 1) % 96;
                if (stall_phase < 24) begin
                    stall_next = 1'b0;
                end else if (stall_phase < 48) begin
                    stall_next = (stall_phase % 3 == 0);
                end else begin
                    stall_next = ($urandom_range(0, 2) == 0);
                end
            end
            out_stall <= stall_next;
        end
    end

    // If the run goes past the cycle limit, it has hung.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles with %0d results outstanding",
                     cycle_count, awaited_resps.size());
            $display("touch_digitiser_codec_regs test failed");
            $finish;
        end
    end

    initial begin
        // The shadow bank starts from the codec's reset values.
        for (int i = 0; i < TB_NUM_REGS; i++) begin
            shadow_regs[i] = '0;
        end
        shadow_regs[REG_REVISION] = REVISION_VAL;
        shadow_regs[REG_VENDOR1] = VENDOR1_VAL;
        shadow_regs[REG_VENDOR2] = VENDOR2_VAL;
        pen_q = 1'b0;
        pen_x_q = '0;
        pen_y_q = '0;
        build_stimulus();

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Wait until every item has gone in and every prediction has been
        // met. Then watch a while longer for stray beats.
        while (req_backlog.size() != 0 || in_valid || awaited_resps.size() != 0) begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Checked %0d results: %0d reads, %0d writes with %0d polls, %0d pen updates",
                 n_checked, n_reads, n_writes, n_polls, n_pens);
        $display("in continuous mode %0d, pops returning a word %0d, channel errors %0d",
                 n_pen_cont, n_pops_hit, n_chan_err);
        if (fail_count == 0) begin
            $display("touch_digitiser_codec_regs test passed");
        end else begin
            $display("touch_digitiser_codec_regs test failed");
        end
        $finish;
    end

endmodule
